>>> rtl/softswitch_memory_mapper_assert.svh
// assertion macros shared by the mapper modules
// the using module must have clk and arst_n in scope
`ifndef SOFTSWITCH_MEMORY_MAPPER_ASSERT_SVH
`define SOFTSWITCH_MEMORY_MAPPER_ASSERT_SVH

// same-cycle implication
`define SSMM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SSMM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/ssmm_pkg.sv
package ssmm_pkg;

	typedef enum logic [1:0] {
		OP_SW_READ   = 2'd0,
		OP_SW_WRITE  = 2'd1,
		OP_TRANSLATE = 2'd2
	} op_t;

	// memory switch flags, msb first
	typedef struct packed {
		logic rombank;
		logic slotc3;
		logic intcx;
		logic lcwrite;
		logic lcread;
		logic lcbank2;
		logic altzp;
		logic auxwr;
		logic auxrd;
		logic store80;
	} mem_sw_t;

	typedef struct packed {
		mem_sw_t    sw;
		logic [6:0] shadow;
	} map_ctl_t;

	typedef struct packed {
		logic        video_hires;
		logic        video_page2;
		logic [15:0] page_number;
		logic [7:0]  write_data;
		logic [7:0]  switch_offset;
	} in_beat_t;

	typedef struct packed {
		logic        page2_value;
		logic        page2_strobe;
		logic        map_covered;
		logic        shadowed;
		logic        is_io;
		logic [15:0] write_page;
		logic [15:0] read_page;
		logic [7:0]  read_data;
	} out_beat_t;

	// shadow control bit positions
	localparam int SH_TEXT   = 0;
	localparam int SH_HIRES1 = 1;
	localparam int SH_HIRES2 = 2;
	localparam int SH_SUPER  = 3;
	localparam int SH_AUX    = 4;
	localparam int SH_TEXT2  = 5;
	localparam int SH_LC     = 6;

	localparam logic [6:0] SHADOW_RESET   = 7'h57;
	localparam logic [7:0] SLOT_ROM_RESET = 8'h80;
	localparam logic [4:0] SPEED_RESET    = 5'h10;
	localparam logic [7:0] ROM_BANK       = 8'hFF;
	localparam logic [7:0] IO_PAGE        = 8'hC0;

	// softswitch offsets
	localparam logic [7:0] OFF_80STORE_OFF = 8'h00;
	localparam logic [7:0] OFF_80STORE_ON  = 8'h01;
	localparam logic [7:0] OFF_AUXRD_OFF   = 8'h02;
	localparam logic [7:0] OFF_AUXRD_ON    = 8'h03;
	localparam logic [7:0] OFF_AUXWR_OFF   = 8'h04;
	localparam logic [7:0] OFF_AUXWR_ON    = 8'h05;
	localparam logic [7:0] OFF_INTCX_OFF   = 8'h06;
	localparam logic [7:0] OFF_INTCX_ON    = 8'h07;
	localparam logic [7:0] OFF_ALTZP_OFF   = 8'h08;
	localparam logic [7:0] OFF_ALTZP_ON    = 8'h09;
	localparam logic [7:0] OFF_SLOTC3_OFF  = 8'h0A;
	localparam logic [7:0] OFF_SLOTC3_ON   = 8'h0B;
	localparam logic [7:0] OFF_RD_LCBANK2  = 8'h11;
	localparam logic [7:0] OFF_RD_LCREAD   = 8'h12;
	localparam logic [7:0] OFF_RD_AUXRD    = 8'h13;
	localparam logic [7:0] OFF_RD_AUXWR    = 8'h14;
	localparam logic [7:0] OFF_RD_INTCX    = 8'h15;
	localparam logic [7:0] OFF_RD_ALTZP    = 8'h16;
	localparam logic [7:0] OFF_RD_SLOTC3   = 8'h17;
	localparam logic [7:0] OFF_RD_80STORE  = 8'h18;
	localparam logic [7:0] OFF_SLOT_ROM    = 8'h2D;
	localparam logic [7:0] OFF_SHADOW      = 8'h35;
	localparam logic [7:0] OFF_SPEED       = 8'h36;
	localparam logic [7:0] OFF_IRQ_EN      = 8'h41;
	localparam logic [7:0] OFF_STATE       = 8'h68;
	localparam logic [7:0] OFF_LC_A_FIRST  = 8'h80;
	localparam logic [7:0] OFF_LC_A_LAST   = 8'h83;
	localparam logic [7:0] OFF_LC_B_FIRST  = 8'h88;
	localparam logic [7:0] OFF_LC_B_LAST   = 8'h8B;

endpackage

>>> rtl/ssmm_switches.sv
`include "softswitch_memory_mapper_assert.svh"

module ssmm_switches (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  ssmm_pkg::op_t      op,
	input  logic [7:0]         off,
	input  logic [7:0]         wdata,
	input  logic               page2,
	output logic [7:0]         rd_data,
	output logic               p2_strobe,
	output logic               p2_value,
	output ssmm_pkg::map_ctl_t ctl
);

	ssmm_pkg::mem_sw_t sw_q, sw_d;
	logic [6:0] shadow_q, shadow_d;
	logic [7:0] slot_rom_q, slot_rom_d;
	logic [4:0] speed_q, speed_d;
	logic [4:0] irq_en_q, irq_en_d;
	logic [7:0] prev_q;
	logic       is_sw_op;
	logic       common_hit;

	assign is_sw_op = (op == ssmm_pkg::OP_SW_READ) || (op == ssmm_pkg::OP_SW_WRITE);

	always_comb begin
		sw_d       = sw_q;
		shadow_d   = shadow_q;
		slot_rom_d = slot_rom_q;
		speed_d    = speed_q;
		irq_en_d   = irq_en_q;
		rd_data    = '0;
		p2_strobe  = 1'b0;
		p2_value   = 1'b0;
		common_hit = 1'b0;
		if (is_sw_op) begin
			common_hit = 1'b1;
			unique case (off) inside
				ssmm_pkg::OFF_80STORE_ON: sw_d.store80 = 1'b1;
				ssmm_pkg::OFF_AUXRD_OFF:  sw_d.auxrd   = 1'b0;
				ssmm_pkg::OFF_AUXRD_ON:   sw_d.auxrd   = 1'b1;
				ssmm_pkg::OFF_AUXWR_OFF:  sw_d.auxwr   = 1'b0;
				ssmm_pkg::OFF_AUXWR_ON:   sw_d.auxwr   = 1'b1;
				ssmm_pkg::OFF_INTCX_OFF:  sw_d.intcx   = 1'b0;
				ssmm_pkg::OFF_INTCX_ON:   sw_d.intcx   = 1'b1;
				ssmm_pkg::OFF_ALTZP_OFF:  sw_d.altzp   = 1'b0;
				ssmm_pkg::OFF_ALTZP_ON:   sw_d.altzp   = 1'b1;
				ssmm_pkg::OFF_SLOTC3_OFF: sw_d.slotc3  = 1'b0;
				ssmm_pkg::OFF_SLOTC3_ON:  sw_d.slotc3  = 1'b1;
				[ssmm_pkg::OFF_LC_A_FIRST:ssmm_pkg::OFF_LC_A_LAST],
				[ssmm_pkg::OFF_LC_B_FIRST:ssmm_pkg::OFF_LC_B_LAST]: begin
					// language card: write enable needs the same odd switch hit twice in a row
					sw_d.lcbank2 = ~off[3];
					sw_d.lcread  = ~(off[0] ^ off[1]);
					if (!off[0]) begin
						sw_d.lcwrite = 1'b0;
					end else if (prev_q == off) begin
						sw_d.lcwrite = 1'b1;
					end
				end
				default: common_hit = 1'b0;
			endcase
		end
		if (is_sw_op && !common_hit) begin
			if (op == ssmm_pkg::OP_SW_READ) begin
				unique case (off)
					ssmm_pkg::OFF_RD_LCBANK2: rd_data = {sw_q.lcbank2, 7'b0};
					ssmm_pkg::OFF_RD_LCREAD:  rd_data = {sw_q.lcread, 7'b0};
					ssmm_pkg::OFF_RD_AUXRD:   rd_data = {sw_q.auxrd, 7'b0};
					ssmm_pkg::OFF_RD_AUXWR:   rd_data = {sw_q.auxwr, 7'b0};
					ssmm_pkg::OFF_RD_INTCX:   rd_data = {sw_q.intcx, 7'b0};
					ssmm_pkg::OFF_RD_ALTZP:   rd_data = {sw_q.altzp, 7'b0};
					ssmm_pkg::OFF_RD_SLOTC3:  rd_data = {sw_q.slotc3, 7'b0};
					ssmm_pkg::OFF_RD_80STORE: rd_data = {sw_q.store80, 7'b0};
					ssmm_pkg::OFF_SLOT_ROM:   rd_data = slot_rom_q;
					ssmm_pkg::OFF_SHADOW:     rd_data = {1'b0, ~shadow_q} & 8'h5F;
					ssmm_pkg::OFF_SPEED:      rd_data = {speed_q[4], 3'b0, speed_q[3:0]};
					ssmm_pkg::OFF_IRQ_EN:     rd_data = {3'b0, irq_en_q};
					ssmm_pkg::OFF_STATE:      rd_data = {sw_q.altzp, page2, sw_q.auxrd,
						sw_q.auxwr, ~sw_q.lcread, sw_q.lcbank2, sw_q.rombank, sw_q.intcx};
					default:                  rd_data = '0;
				endcase
			end else begin
				unique case (off)
					ssmm_pkg::OFF_80STORE_OFF: sw_d.store80 = 1'b0;
					ssmm_pkg::OFF_SLOT_ROM:    slot_rom_d = wdata;
					ssmm_pkg::OFF_SHADOW:      shadow_d = ~wdata[6:0];
					ssmm_pkg::OFF_SPEED:       speed_d = {wdata[7], wdata[3:0]};
					ssmm_pkg::OFF_IRQ_EN:      irq_en_d = wdata[4:0];
					ssmm_pkg::OFF_STATE: begin
						sw_d.intcx   = wdata[0];
						sw_d.rombank = wdata[1];
						sw_d.lcbank2 = wdata[2];
						sw_d.lcread  = ~wdata[3];
						sw_d.auxwr   = wdata[4];
						sw_d.auxrd   = wdata[5];
						sw_d.altzp   = wdata[7];
						p2_strobe    = 1'b1;
						p2_value     = wdata[6];
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q       <= '0;
			shadow_q   <= ssmm_pkg::SHADOW_RESET;
			slot_rom_q <= ssmm_pkg::SLOT_ROM_RESET;
			speed_q    <= ssmm_pkg::SPEED_RESET;
			irq_en_q   <= '0;
			prev_q     <= '0;
		end else if (en) begin
			sw_q       <= sw_d;
			shadow_q   <= shadow_d;
			slot_rom_q <= slot_rom_d;
			speed_q    <= speed_d;
			irq_en_q   <= irq_en_d;
			if (is_sw_op) begin
				prev_q <= off;
			end
		end
	end

	assign ctl.sw     = sw_q;
	assign ctl.shadow = shadow_q;

	`SSMM_ASSERT_NEXT(a_lcwrite_double, !$past(en && off[0] && (prev_q == off) && is_sw_op) && !sw_q.lcwrite, !$rose(sw_q.lcwrite) || $past(en), "lcwrite set without a qualifying access")
	`SSMM_ASSERT_NOW(a_lcwrite_cause, $rose(sw_q.lcwrite), $past(en && is_sw_op) && ($past(off) == $past(prev_q) || $past(off) == ssmm_pkg::OFF_STATE || $past(off[0])), "lcwrite rose without a language card access")
	`SSMM_ASSERT_NOW(a_strobe_only_write, p2_strobe, op == ssmm_pkg::OP_SW_WRITE && rd_data == 8'h00, "page2 strobe outside a write")

endmodule

>>> rtl/ssmm_xlate.sv
module ssmm_xlate (
	input  logic               [15:0] page_number,
	input  logic                      page2,
	input  logic                      hires,
	input  ssmm_pkg::map_ctl_t        ctl,
	output logic               [15:0] read_page,
	output logic               [15:0] write_page,
	output logic                      is_io,
	output logic                      shadowed,
	output logic                      map_covered
);

	logic [7:0] bank;
	logic [7:0] pg;
	logic       rdaux, wraux;
	logic       lc_on;
	logic [7:0] lc_src;
	logic [7:0] ram_pg;
	logic [15:0] lc_rp, lc_wp;
	logic       lc_io;
	logic       sh_text, sh_text2, sh_hr1, sh_hr2, sup, aux;
	logic       in_text, in_text2, in_hr1, in_hr2, in_hi_aux;

	assign bank = page_number[15:8];
	assign pg   = page_number[7:0];

	// language card window, pages c0-ff
	always_comb begin
		unique case (bank)
			8'h00:   lc_src = {7'b0, ctl.sw.altzp};
			default: lc_src = bank;
		endcase
		ram_pg = (pg < 8'hE0 && !ctl.sw.lcbank2) ? pg - 8'h10 : pg;
		lc_io  = 1'b0;
		if (pg == ssmm_pkg::IO_PAGE) begin
			lc_rp = page_number;
			lc_wp = page_number;
			lc_io = 1'b1;
		end else if (pg < 8'hD0) begin
			lc_rp = {ssmm_pkg::ROM_BANK, pg};
			lc_wp = {ssmm_pkg::ROM_BANK, pg};
		end else begin
			lc_rp = ctl.sw.lcread  ? {lc_src, ram_pg} : {ssmm_pkg::ROM_BANK, pg};
			lc_wp = ctl.sw.lcwrite ? {lc_src, ram_pg} : {ssmm_pkg::ROM_BANK, pg};
		end
	end

	// shadow windows
	assign sh_text   = ctl.shadow[ssmm_pkg::SH_TEXT];
	assign sh_text2  = ctl.shadow[ssmm_pkg::SH_TEXT2];
	assign sh_hr1    = ctl.shadow[ssmm_pkg::SH_HIRES1];
	assign sh_hr2    = ctl.shadow[ssmm_pkg::SH_HIRES2];
	assign sup       = ctl.shadow[ssmm_pkg::SH_SUPER];
	assign aux       = ctl.shadow[ssmm_pkg::SH_AUX];
	assign lc_on     = ctl.shadow[ssmm_pkg::SH_LC];
	assign in_text   = pg[7:2] == 6'b000001;
	assign in_text2  = pg[7:2] == 6'b000010;
	assign in_hr1    = pg[7:5] == 3'b001;
	assign in_hr2    = pg[7:5] == 3'b010;
	assign in_hi_aux = pg >= 8'h60 && pg < 8'hA0;

	always_comb begin
		rdaux       = ctl.sw.auxrd;
		wraux       = ctl.sw.auxwr;
		read_page   = page_number;
		write_page  = page_number;
		is_io       = 1'b0;
		shadowed    = 1'b0;
		map_covered = 1'b0;
		if (bank == 8'h00) begin
			map_covered = 1'b1;
			if (pg < 8'h02) begin
				rdaux = ctl.sw.altzp;
				wraux = ctl.sw.altzp;
			end else if (ctl.sw.store80 && (in_text || (hires && in_hr1))) begin
				rdaux = page2;
				wraux = page2;
			end
			if (pg >= ssmm_pkg::IO_PAGE && lc_on) begin
				read_page  = lc_rp;
				write_page = lc_wp;
				is_io      = lc_io;
			end else begin
				read_page  = {7'b0, rdaux, pg};
				write_page = {7'b0, wraux, pg};
			end
			shadowed = (in_text && sh_text) || (in_text2 && sh_text2) ||
				(in_hr1 && sh_hr1) || (in_hr2 && sh_hr2);
		end else if (bank == 8'h01) begin
			map_covered = 1'b1;
			if (pg >= ssmm_pkg::IO_PAGE && lc_on) begin
				read_page  = lc_rp;
				write_page = lc_wp;
				is_io      = lc_io;
			end
			shadowed = (in_text && sh_text) || (in_text2 && sh_text2) ||
				(in_hr1 && ((sh_hr1 && aux) || sup)) ||
				(in_hr2 && ((sh_hr2 && aux) || sup)) ||
				(in_hi_aux && (aux || sup));
		end else if ((bank == 8'hE0 || bank == 8'hE1) && pg >= ssmm_pkg::IO_PAGE) begin
			map_covered = 1'b1;
			read_page   = lc_rp;
			write_page  = lc_wp;
			is_io       = lc_io;
		end
	end

endmodule

>>> rtl/softswitch_memory_mapper.sv
// channel  | dir | tvalid/tready        | payload
// ---------+-----+----------------------+---------------------------------------------
// s_*      | in  | s_tvalid, s_tready   | s_tdata (40b), s_tuser[1:0] operation
// m_*      | out | m_tvalid, m_tready   | m_tdata (48b) result beat
//
// one beat per cycle sustained while m_tready does not stall the output; a taken beat passes
// from the input register to the result register, and leaves from the result register
// switch state is updated when a beat moves from the input register to the result
// register, so each translate sees every earlier switch access
// arst_n clears both stage valids and loads the switch reset values
// a stall on m_tready holds the result register; the input register still takes one
// more beat if it is empty, after which s_tready drops until the result is taken
`include "softswitch_memory_mapper_assert.svh"

module softswitch_memory_mapper (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// switch_offset[7:0], write_data[15:8], page_number[31:16], video_page2[32],
	// video_hires[33], zero fill [39:34]
	input  logic [39:0] s_tdata,
	// operation[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// read_data[7:0], read_page[23:8], write_page[39:24], is_io[40], shadowed[41],
	// map_covered[42], page2_strobe[43], page2_value[44], zero fill [47:45]
	output logic [47:0] m_tdata
);

	// input register
	logic               valid_s1;
	ssmm_pkg::op_t      op_s1;
	ssmm_pkg::in_beat_t in_s1;

	// result register
	logic                valid_s2;
	ssmm_pkg::out_beat_t res_s2;

	logic                advance;
	logic                step_en;
	ssmm_pkg::out_beat_t res;
	ssmm_pkg::map_ctl_t  ctl;
	logic [7:0]          sw_rd_data;
	logic                sw_p2_strobe, sw_p2_value;
	logic [15:0]         xl_rp, xl_wp;
	logic                xl_io, xl_sh, xl_cov;

	// result register free or being emptied this cycle
	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign step_en  = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1 <= ssmm_pkg::op_t'(s_tuser);
			in_s1 <= s_tdata[$bits(ssmm_pkg::in_beat_t)-1:0];
		end
	end

	ssmm_switches u_switches (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (step_en),
		.op        (op_s1),
		.off       (in_s1.switch_offset),
		.wdata     (in_s1.write_data),
		.page2     (in_s1.video_page2),
		.rd_data   (sw_rd_data),
		.p2_strobe (sw_p2_strobe),
		.p2_value  (sw_p2_value),
		.ctl       (ctl)
	);

	ssmm_xlate u_xlate (
		.page_number (in_s1.page_number),
		.page2       (in_s1.video_page2),
		.hires       (in_s1.video_hires),
		.ctl         (ctl),
		.read_page   (xl_rp),
		.write_page  (xl_wp),
		.is_io       (xl_io),
		.shadowed    (xl_sh),
		.map_covered (xl_cov)
	);

	// fields not owned by the operation stay zero
	always_comb begin
		res = '0;
		case (op_s1)
			ssmm_pkg::OP_SW_READ: res.read_data = sw_rd_data;
			ssmm_pkg::OP_SW_WRITE: begin
				res.page2_strobe = sw_p2_strobe;
				res.page2_value  = sw_p2_value;
			end
			ssmm_pkg::OP_TRANSLATE: begin
				res.read_page   = xl_rp;
				res.write_page  = xl_wp;
				res.is_io       = xl_io;
				res.shadowed    = xl_sh;
				res.map_covered = xl_cov;
			end
			default: res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {3'b0, res_s2};

	`SSMM_ASSERT_NEXT(a_stage_moves, step_en, valid_s2, "input beat lost on its way to the result register")
	`SSMM_ASSERT_NOW(a_ready_when_empty, !valid_s1, s_tready, "input register empty but not ready")
	`SSMM_ASSERT_NOW(a_uncovered_identity, valid_s2 && !res_s2.map_covered, (res_s2.read_page == res_s2.write_page) && !res_s2.is_io && !res_s2.shadowed, "uncovered result not identity")
	`SSMM_ASSERT_NOW(a_io_page, valid_s2 && res_s2.is_io, res_s2.map_covered && (res_s2.read_page[7:0] == ssmm_pkg::IO_PAGE) && (res_s2.read_page == res_s2.write_page), "io flag on a page other than c0")

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import ssmm_pkg::*;

	// the block takes a fourth operation code and must answer it with an all-zero beat
	localparam logic [1:0] OP_RESERVED = 2'd3;
	localparam int STALL_LIMIT = 2000;
	localparam int LONG_HOLD = 80;
	localparam int PHASE_BEATS = 270;

	// switch state and page mapping, with the results owed by the block in arrival order
	class mapper_board;
		mem_sw_t    sw;
		logic [6:0] shadow;
		logic [7:0] slot_rom;
		logic [4:0] speed;
		logic [4:0] irq_en;
		logic [7:0] last_off;
		out_beat_t  due_beats[$];
		int checked, mismatches;
		int n_reads, n_writes, n_maps, n_mapped, n_reserved;

		function new();
			sw = '0;
			shadow = SHADOW_RESET;
			slot_rom = SLOT_ROM_RESET;
			speed = SPEED_RESET;
			irq_en = '0;
			last_off = '0;
		endfunction

		// switches that act the same on read and write; 0 when the offset is not one
		function bit common_access(input logic [7:0] off);
			case (off)
				OFF_80STORE_ON: sw.store80 = 1'b1;
				OFF_AUXRD_OFF:  sw.auxrd = 1'b0;
				OFF_AUXRD_ON:   sw.auxrd = 1'b1;
				OFF_AUXWR_OFF:  sw.auxwr = 1'b0;
				OFF_AUXWR_ON:   sw.auxwr = 1'b1;
				OFF_INTCX_OFF:  sw.intcx = 1'b0;
				OFF_INTCX_ON:   sw.intcx = 1'b1;
				OFF_ALTZP_OFF:  sw.altzp = 1'b0;
				OFF_ALTZP_ON:   sw.altzp = 1'b1;
				OFF_SLOTC3_OFF: sw.slotc3 = 1'b0;
				OFF_SLOTC3_ON:  sw.slotc3 = 1'b1;
				default: begin
					if (!((off >= OFF_LC_A_FIRST && off <= OFF_LC_A_LAST) ||
							(off >= OFF_LC_B_FIRST && off <= OFF_LC_B_LAST)))
						return 1'b0;
					// language card: write enable needs the same odd switch twice in a row
					sw.lcbank2 = !off[3];
					sw.lcread = (off[0] == off[1]);
					if (!off[0])
						sw.lcwrite = 1'b0;
					else if (last_off == off)
						sw.lcwrite = 1'b1;
				end
			endcase
			return 1'b1;
		endfunction

		// pages c0-ff of a language card bank; src is the ram bank behind it
		function void lc_map(input logic [7:0] dst, input logic [7:0] src, input logic [7:0] pg,
				inout out_beat_t r);
			logic [7:0] ram;
			ram = pg;
			if (pg == IO_PAGE) begin
				r.read_page = {dst, pg};
				r.write_page = {dst, pg};
				r.is_io = 1'b1;
			end else if (pg < 8'hD0) begin
				r.read_page = {ROM_BANK, pg};
				r.write_page = {ROM_BANK, pg};
			end else begin
				if (pg < 8'hE0 && !sw.lcbank2)
					ram = pg - 8'h10;
				r.read_page = sw.lcread ? {src, ram} : {ROM_BANK, pg};
				r.write_page = sw.lcwrite ? {src, ram} : {ROM_BANK, pg};
			end
		endfunction

		function logic shadow_on(input logic bank0, input logic [7:0] pg);
			logic sup, aux;
			sup = shadow[SH_SUPER];
			aux = shadow[SH_AUX];
			if (pg >= 8'h04 && pg < 8'h08) return shadow[SH_TEXT];
			if (pg >= 8'h08 && pg < 8'h0C) return shadow[SH_TEXT2];
			if (bank0) begin
				if (pg >= 8'h20 && pg < 8'h40) return shadow[SH_HIRES1];
				if (pg >= 8'h40 && pg < 8'h60) return shadow[SH_HIRES2];
				return 1'b0;
			end
			if (pg >= 8'h20 && pg < 8'h40) return (shadow[SH_HIRES1] && aux) || sup;
			if (pg >= 8'h40 && pg < 8'h60) return (shadow[SH_HIRES2] && aux) || sup;
			if (pg >= 8'h60 && pg < 8'hA0) return aux || sup;
			return 1'b0;
		endfunction

		function void take_access(input logic [1:0] op, input in_beat_t b);
			out_beat_t r;
			logic [7:0] off, d, bank, pg;
			logic rdaux, wraux;
			r = '0;
			off = b.switch_offset;
			d = b.write_data;
			bank = b.page_number[15:8];
			pg = b.page_number[7:0];
			case (op)
				OP_SW_READ: begin
					n_reads++;
					if (!common_access(off)) begin
						case (off)
							OFF_RD_LCBANK2: r.read_data = {sw.lcbank2, 7'b0};
							OFF_RD_LCREAD:  r.read_data = {sw.lcread, 7'b0};
							OFF_RD_AUXRD:   r.read_data = {sw.auxrd, 7'b0};
							OFF_RD_AUXWR:   r.read_data = {sw.auxwr, 7'b0};
							OFF_RD_INTCX:   r.read_data = {sw.intcx, 7'b0};
							OFF_RD_ALTZP:   r.read_data = {sw.altzp, 7'b0};
							OFF_RD_SLOTC3:  r.read_data = {sw.slotc3, 7'b0};
							OFF_RD_80STORE: r.read_data = {sw.store80, 7'b0};
							OFF_SLOT_ROM:   r.read_data = slot_rom;
							// text2 and bit 7 always read back as zero
							OFF_SHADOW:     r.read_data = {1'b0, ~shadow[SH_LC], 1'b0, ~shadow[4:0]};
							OFF_SPEED:      r.read_data = {speed[4], 3'b000, speed[3:0]};
							OFF_IRQ_EN:     r.read_data = {3'b000, irq_en};
							OFF_STATE: r.read_data = {sw.altzp, b.video_page2, sw.auxrd, sw.auxwr,
								!sw.lcread, sw.lcbank2, sw.rombank, sw.intcx};
							default: r.read_data = 8'h00;
						endcase
					end
					last_off = off;
				end
				OP_SW_WRITE: begin
					n_writes++;
					if (off == OFF_80STORE_OFF) begin
						sw.store80 = 1'b0;
					end else if (!common_access(off)) begin
						case (off)
							OFF_SLOT_ROM: slot_rom = d;
							OFF_SHADOW:   shadow = ~d[6:0];
							OFF_SPEED:    speed = {d[7], d[3:0]};
							OFF_IRQ_EN:   irq_en = d[4:0];
							OFF_STATE: begin
								sw.intcx = d[0];
								sw.rombank = d[1];
								sw.lcbank2 = d[2];
								sw.lcread = !d[3];
								sw.auxwr = d[4];
								sw.auxrd = d[5];
								sw.altzp = d[7];
								r.page2_strobe = 1'b1;
								r.page2_value = d[6];
							end
							default: ;
						endcase
					end
					last_off = off;
				end
				OP_TRANSLATE: begin
					n_maps++;
					r.read_page = b.page_number;
					r.write_page = b.page_number;
					if (bank == 8'h00) begin
						r.map_covered = 1'b1;
						rdaux = sw.auxrd;
						wraux = sw.auxwr;
						// zero page and stack follow altzp; text page 1, and hires page 1 when hires is set, follow 80store
						if (pg < 8'h02) begin
							rdaux = sw.altzp;
							wraux = sw.altzp;
						end else if (sw.store80 && ((pg >= 8'h04 && pg < 8'h08) ||
								(b.video_hires && pg >= 8'h20 && pg < 8'h40))) begin
							rdaux = b.video_page2;
							wraux = b.video_page2;
						end
						if (pg >= IO_PAGE && shadow[SH_LC]) begin
							lc_map(8'h00, {7'b0, sw.altzp}, pg, r);
						end else begin
							r.read_page = {7'b0, rdaux, pg};
							r.write_page = {7'b0, wraux, pg};
						end
						r.shadowed = shadow_on(1'b1, pg);
					end else if (bank == 8'h01) begin
						r.map_covered = 1'b1;
						if (pg >= IO_PAGE && shadow[SH_LC])
							lc_map(bank, bank, pg, r);
						r.shadowed = shadow_on(1'b0, pg);
					end else if ((bank == 8'hE0 || bank == 8'hE1) && pg >= IO_PAGE) begin
						r.map_covered = 1'b1;
						lc_map(bank, bank, pg, r);
					end
					if (r.map_covered)
						n_mapped++;
				end
				default: n_reserved++;
			endcase
			due_beats.push_back(r);
		endfunction

		function void check_output(input logic [47:0] word);
			out_beat_t got, want;
			string diff;
			got = word[44:0];
			checked++;
			if (due_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d arrived with nothing owed: %h", checked, word);
				return;
			end
			want = due_beats.pop_front();
			diff = "";
			if (got.read_data !== want.read_data) diff = {diff, " read_data"};
			if (got.read_page !== want.read_page) diff = {diff, " read_page"};
			if (got.write_page !== want.write_page) diff = {diff, " write_page"};
			if (got.is_io !== want.is_io) diff = {diff, " is_io"};
			if (got.shadowed !== want.shadowed) diff = {diff, " shadowed"};
			if (got.map_covered !== want.map_covered) diff = {diff, " map_covered"};
			if (got.page2_strobe !== want.page2_strobe) diff = {diff, " page2_strobe"};
			if (got.page2_value !== want.page2_value) diff = {diff, " page2_value"};
			if (word[47:45] !== 3'b000) diff = {diff, " zero_fill"};
			if (diff == "")
				return;
			mismatches++;
			if (mismatches <= 10) begin
				$display("result %0d differs in:%s", checked, diff);
				$display("  want rd=%h rp=%h wp=%h io=%b sh=%b cov=%b stb=%b p2=%b",
					want.read_data, want.read_page, want.write_page, want.is_io,
					want.shadowed, want.map_covered, want.page2_strobe, want.page2_value);
				$display("  got  rd=%h rp=%h wp=%h io=%b sh=%b cov=%b stb=%b p2=%b fill=%b",
					got.read_data, got.read_page, got.write_page, got.is_io,
					got.shadowed, got.map_covered, got.page2_strobe, got.page2_value,
					word[47:45]);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;

	logic rx_hold = 1'b0;
	int sender_idle = 0;
	int rx_stall = 0;
	int beats_sent = 0;
	int idle_cycles = 0;
	mapper_board board;

	softswitch_memory_mapper dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #1 clk = ~clk;

	// receiver: random stalls, or a solid hold while rx_hold is up
	always @(posedge clk) begin
		m_tready <= !rx_hold && ($urandom_range(99) >= rx_stall);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				board.take_access(s_tuser, s_tdata[33:0]);
			if (m_tvalid && m_tready)
				board.check_output(m_tdata);
		end
	end

	// watchdog on cycles with no beat moving either way
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("no beat moved for %0d cycles, %0d results still owed",
				idle_cycles, board.due_beats.size());
			$display("CHECK FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_beat(input logic [1:0] op, input in_beat_t b);
		while ($urandom_range(99) < sender_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {6'b0, b};
		do @(posedge clk); while (!s_tready);
		beats_sent++;
	endtask

	// every field random, so unused fields toggle as well
	function automatic in_beat_t rand_beat();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[33:0];
	endfunction

	task automatic access_switch(input logic [1:0] op, input logic [7:0] off, input logic [7:0] d);
		in_beat_t b;
		b = rand_beat();
		b.switch_offset = off;
		b.write_data = d;
		send_beat(op, b);
	endtask

	task automatic translate_page(input logic [15:0] pn, input logic [1:0] video);
		in_beat_t b;
		b = rand_beat();
		b.page_number = pn;
		b.video_page2 = video[0];
		b.video_hires = video[1];
		send_beat(OP_TRANSLATE, b);
	endtask

	function automatic logic [15:0] lc_page();
		logic [7:0] bank;
		case ($urandom_range(3))
			0: bank = 8'h00;
			1: bank = 8'h01;
			2: bank = 8'hE0;
			default: bank = 8'hE1;
		endcase
		return {bank, 8'($urandom_range(255, IO_PAGE))};
	endfunction

	function automatic logic [15:0] pick_page();
		case ($urandom_range(5))
			0: return 16'($urandom_range(16'hFFFF));
			1: return {8'h00, 8'($urandom_range(255))};
			2: return {8'h00, 8'($urandom_range(8'h5F))};
			3: return {8'h01, 8'($urandom_range(8'hBF))};
			4: return {8'h01, 8'($urandom_range(255))};
			default: return lc_page();
		endcase
	endfunction

	function automatic logic [7:0] pick_switch();
		case ($urandom_range(9))
			0, 1: return 8'($urandom_range(OFF_SLOTC3_ON, OFF_80STORE_OFF));
			2: return 8'($urandom_range(OFF_RD_80STORE, OFF_RD_LCBANK2));
			3: return OFF_SLOT_ROM;
			4: return OFF_SHADOW;
			5: return OFF_SPEED;
			6: return OFF_IRQ_EN;
			7: return OFF_STATE;
			8: return 8'($urandom_range(OFF_LC_B_LAST + 4, OFF_LC_A_FIRST));
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic random_burst();
		logic [7:0] off;
		int pick;
		pick = $urandom_range(99);
		if (pick < 28) begin
			// language card switch hit twice, mostly odd, then pages behind it
			off = 8'(OFF_LC_A_FIRST + 8 * $urandom_range(1) + $urandom_range(3));
			if ($urandom_range(3) != 0)
				off[0] = 1'b1;
			access_switch($urandom_range(1) ? OP_SW_WRITE : OP_SW_READ, off, 8'($urandom));
			if ($urandom_range(4) == 0)
				access_switch($urandom_range(1) ? OP_SW_WRITE : OP_SW_READ, pick_switch(),
					8'($urandom));
			access_switch($urandom_range(1) ? OP_SW_WRITE : OP_SW_READ, off, 8'($urandom));
			repeat ($urandom_range(4, 1))
				translate_page(lc_page(), 2'($urandom_range(3)));
		end else if (pick < 55) begin
			translate_page(pick_page(), 2'($urandom_range(3)));
		end else if (pick < 85) begin
			access_switch($urandom_range(1) ? OP_SW_WRITE : OP_SW_READ, pick_switch(),
				8'($urandom));
		end else if (pick < 92) begin
			// 80store against the text and hires pages of bank 0
			access_switch(OP_SW_WRITE, $urandom_range(1) ? OFF_80STORE_ON : OFF_80STORE_OFF,
				8'($urandom));
			translate_page({8'h00, 8'($urandom_range(8'h3F))}, 2'($urandom_range(3)));
		end else begin
			send_beat(2'($urandom_range(3)), rand_beat());
		end
	endtask

	// sender steps back and waits for every owed result
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (board.due_beats.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int send_idle_pct[4];
		int recv_stall_pct[4];
		int target;
		bit held;
		send_idle_pct = '{0, 79, 0, 36};
		recv_stall_pct = '{0, 0, 79, 36};
		held = 1'b0;
		board = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset state, status quirks, 80store, language card, shadowing, io page
		translate_page(16'h0000, 2'b00);
		translate_page(16'hFFFF, 2'b11);
		access_switch(OP_SW_READ, OFF_RD_AUXRD, 8'h00);
		access_switch(OP_SW_WRITE, OFF_AUXRD_ON, 8'hFF);
		access_switch(OP_SW_READ, OFF_RD_AUXRD, 8'h00);
		access_switch(OP_SW_READ, OFF_80STORE_OFF, 8'h00);
		access_switch(OP_SW_WRITE, OFF_80STORE_ON, 8'h00);
		translate_page(16'h0004, 2'b01);
		translate_page(16'h0025, 2'b10);
		translate_page(16'h0003, 2'b00);
		translate_page(16'h0050, 2'b00);
		access_switch(OP_SW_READ, OFF_LC_B_LAST, 8'h00);
		access_switch(OP_SW_WRITE, OFF_LC_B_LAST, 8'h00);
		translate_page(16'h00D4, 2'b00);
		translate_page(16'h01C0, 2'b00);
		translate_page(16'hE1FF, 2'b00);
		access_switch(OP_SW_WRITE, OFF_SHADOW, 8'h00);
		access_switch(OP_SW_READ, OFF_SHADOW, 8'h00);
		translate_page(16'h0109, 2'b00);
		access_switch(OP_SW_WRITE, OFF_STATE, 8'hFF);
		access_switch(OP_SW_READ, OFF_STATE, 8'h00);
		access_switch(OP_SW_WRITE, OFF_SPEED, 8'hFF);
		access_switch(OP_SW_READ, OFF_SPEED, 8'h00);
		access_switch(OP_SW_WRITE, 8'h46, 8'hFF);
		access_switch(OP_SW_READ, 8'h7F, 8'h00);
		send_beat(OP_RESERVED, 34'h3_FFFF_FFFF);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			sender_idle = send_idle_pct[ph];
			rx_stall = recv_stall_pct[ph];
			target = beats_sent + PHASE_BEATS;
			while (beats_sent < target) begin
				// long output hold while the sender keeps offering, so the input backs up
				if (ph == 0 && !held && beats_sent + 150 >= target) begin
					held = 1'b1;
					fork
						begin
							rx_hold <= 1'b1;
							repeat (LONG_HOLD) @(posedge clk);
							rx_hold <= 1'b0;
						end
					join_none
				end
				random_burst();
			end
			drain();
		end

		repeat (8) @(posedge clk);
		if (board.due_beats.size() != 0)
			board.mismatches += board.due_beats.size();
		$display("covered %0d switch reads, %0d switch writes, %0d translations (%0d mapped),",
			board.n_reads, board.n_writes, board.n_maps, board.n_mapped);
		$display("%0d reserved-op beats; %0d results compared, %0d mismatches",
			board.n_reserved, board.checked, board.mismatches);
		if (board.mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/ssmm_pkg.sv
rtl/ssmm_switches.sv
rtl/ssmm_xlate.sv
rtl/softswitch_memory_mapper.sv
sim/tb_top.sv
